FILE: rtl/u8u16_pkg.sv
// Shared types, constants and helpers for the UTF-8 to UTF-16LE transcoder.
package u8u16_pkg;

    localparam int unsigned MAX_STRING_BYTES = 65536;
    localparam int unsigned CountFieldMax    = 'h3FFFF;
    localparam int unsigned CountCapInt      = (2 * MAX_STRING_BYTES > CountFieldMax) ?
                                               CountFieldMax : 2 * MAX_STRING_BYTES;
    localparam logic [17:0] COUNT_CAP        = 18'(CountCapInt);

    localparam logic [20:0] BMP_LIMIT = 21'h010000;
    localparam logic [20:0] MAX_POINT = 21'h10FFFF;
    localparam logic [15:0] HI_SURR   = 16'hD800;
    localparam logic [15:0] LO_SURR   = 16'hDC00;

    typedef struct packed {
        logic [1:0]  pending;
        logic [20:0] point;
        logic [17:0] count;
    } t_state;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        end_of_string;
        logic [17:0] byte_total;
    } t_result;

    function automatic logic [17:0] sat_add2(input logic [17:0] c);
        logic [18:0] s;
        s = {1'b0, c} + 19'd2;
        return (s > {1'b0, COUNT_CAP}) ? COUNT_CAP : s[17:0];
    endfunction

endpackage

FILE: rtl/u8u16_in_if.sv
// Request channel carrying one UTF-8 byte per request.
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

FILE: rtl/u8u16_out_if.sv
// Result channel carrying one UTF-16 code unit or end marker per request.
interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        end_of_string;
    logic [17:0] byte_total;

    modport source (output valid, output code_unit, output unit_valid,
                    output end_of_string, output byte_total, input ready);
    modport sink   (input valid, input code_unit, input unit_valid,
                    input end_of_string, input byte_total, output ready);
endinterface

FILE: rtl/u8u16_step.sv
// Combinational decode step: one byte plus state gives next state and up to two results.
module u8u16_step (
    input  u8u16_pkg::t_state  i_state,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output u8u16_pkg::t_state  o_next,
    output u8u16_pkg::t_result o_res0,
    output u8u16_pkg::t_result o_res1,
    output logic [1:0]         o_n
);
    import u8u16_pkg::*;

    t_state      s_dec;
    logic        emit;
    logic [20:0] cp;
    logic [20:0] v;
    logic [17:0] c1;
    logic [17:0] c2;
    logic [17:0] cnt_next;

    always_comb begin
        s_dec = i_state;
        emit  = 1'b0;
        cp    = '0;
        if (i_state.pending != 2'd0) begin
            s_dec.point   = {i_state.point[14:0], i_byte[5:0]};
            s_dec.pending = i_state.pending - 2'd1;
            emit          = (i_state.pending == 2'd1);
            cp            = {i_state.point[14:0], i_byte[5:0]};
        end else if (!i_byte[7]) begin
            emit = 1'b1;
            cp   = {13'd0, i_byte};
        end else if (i_byte[7:5] == 3'b110) begin
            s_dec.point   = {16'd0, i_byte[4:0]};
            s_dec.pending = 2'd1;
        end else if (i_byte[7:4] == 4'b1110) begin
            s_dec.point   = {17'd0, i_byte[3:0]};
            s_dec.pending = 2'd2;
        end else if (i_byte[7:3] == 5'b11110) begin
            s_dec.point   = {18'd0, i_byte[2:0]};
            s_dec.pending = 2'd3;
        end
    end

    assign v  = cp - BMP_LIMIT;
    assign c1 = sat_add2(i_state.count);
    assign c2 = sat_add2(c1);

    always_comb begin
        o_res0   = '0;
        o_res1   = '0;
        o_n      = 2'd0;
        cnt_next = i_state.count;
        if (emit) begin
            if (cp < BMP_LIMIT) begin
                o_n               = 2'd1;
                o_res0.code_unit  = cp[15:0];
                o_res0.unit_valid = 1'b1;
                cnt_next          = c1;
            end else if (cp <= MAX_POINT) begin
                o_n               = 2'd2;
                o_res0.code_unit  = HI_SURR | {6'd0, v[19:10]};
                o_res0.unit_valid = 1'b1;
                o_res1.code_unit  = LO_SURR | {6'd0, v[9:0]};
                o_res1.unit_valid = 1'b1;
                cnt_next          = c2;
            end
        end

        o_next       = s_dec;
        o_next.count = cnt_next;

        if (i_last) begin
            o_next = '0;
            if (o_n == 2'd2) begin
                o_res1.end_of_string = 1'b1;
                o_res1.byte_total    = cnt_next;
            end else begin
                o_n                  = 2'd1;
                o_res0.end_of_string = 1'b1;
                o_res0.byte_total    = cnt_next;
            end
        end
    end

endmodule

FILE: rtl/utf8_to_utf16le_lenient_encoder.sv
// A byte taken into the input register is decoded combinationally, and its results are
// loaded into the result register. Throughput: one byte per cycle while the result register
// can take its results; a surrogate pair fills both of its entries, so a byte after it that
// yields a result waits in the input register. Reset (i_rst_n low at a clock edge) empties
// both registers and clears the decode state and the byte count; no clearing pass is needed.
module utf8_to_utf16le_lenient_encoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    u8u16_in_if.sink           i_in,
    u8u16_out_if.source        o_out
);
    import u8u16_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;

    t_state     r_state;
    t_state     n_state;
    t_result    res0;
    t_result    res1;
    logic [1:0] res_n;

    logic [1:0] r_cnt;
    t_result    r_res0;
    t_result    r_res1;

    logic pop;
    logic can_load;
    logic consume;

    u8u16_step u_step (
        .i_state (r_state),
        .i_byte  (r_byte),
        .i_last  (r_last),
        .o_next  (n_state),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_n     (res_n)
    );

    assign pop      = (r_cnt != 2'd0) && o_out.ready;
    assign can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign consume  = r_in_valid && ((res_n == 2'd0) || can_load);

    assign i_in.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.in_byte;
            r_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (consume) begin
            r_state <= n_state;
        end
    end

    // Two-deep result register; load only when it is empty or its last entry drains this cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (consume && (res_n != 2'd0)) begin
            r_cnt <= res_n;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && (res_n != 2'd0)) begin
            r_res0 <= res0;
            r_res1 <= res1;
        end else if (pop) begin
            r_res0 <= r_res1;
        end
    end

    assign o_out.valid         = (r_cnt != 2'd0);
    assign o_out.code_unit     = r_res0.code_unit;
    assign o_out.unit_valid    = r_res0.unit_valid;
    assign o_out.end_of_string = r_res0.end_of_string;
    assign o_out.byte_total    = r_res0.byte_total;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result register count out of range");

    a_marker_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.unit_valid) |-> o_out.end_of_string)
        else $error("bare marker without end of string");

    a_pair_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (r_res0.code_unit[15:10] == 6'b110110))
        else $error("two queued results without high surrogate at head");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_last) |=> ((r_state.pending == 2'd0) && (r_state.count == 18'd0)))
        else $error("state not cleared after end of string");

endmodule
